// File: src/fpcd_pkg.sv
// shared types and constants for the framed packet checksum decoder
// used by every module of the block; no dependencies
`timescale 1ns / 1ps

package fpcd_pkg;

  localparam logic [7:0] START_MARK = 8'h99;
  localparam logic [7:0] MIN_LENGTH = 8'd6;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned CFG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;

  // register indexes, byte address is 8 times the index
  localparam logic [2:0] REG_FIRST_ID   = 3'd0;
  localparam logic [2:0] REG_FIRST_MSG  = 3'd1;
  localparam logic [2:0] REG_SECOND_ID  = 3'd2;
  localparam logic [2:0] REG_MASK_0     = 3'd3;
  localparam logic [2:0] REG_MASK_1     = 3'd4;
  localparam logic [2:0] REG_MASK_2     = 3'd5;
  localparam logic [2:0] REG_MASK_3     = 3'd6;

  typedef enum logic [1:0] {
    OP_PAYLOAD   = 2'd0,
    OP_HUNT      = 2'd1,
    OP_LENGTH    = 2'd2,
    OP_FRAME_END = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_START      = 3'd1,
    ST_CHECKSUM   = 3'd2,
    ST_SENDER     = 3'd3,
    ST_FIRST_MSG  = 3'd4,
    ST_SECOND_MSG = 3'd5,
    ST_LENGTH     = 3'd6
  } status_t;

  // one classified item handed from front to back
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] src;
    logic [7:0] msg;
    logic       sum_ok;
  } rec_t;

  typedef struct packed {
    logic [7:0]       first_id;
    logic [7:0]       first_msg;
    logic [7:0]       second_id;
    logic [3:0][63:0] known_mask;
  } cfg_t;

endpackage

// File: src/fpcd_cfg.sv
// configuration register bank behind the apb-style port
// depends on fpcd_pkg
`timescale 1ns / 1ps

module fpcd_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpcd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fpcd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fpcd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  output fpcd_pkg::cfg_t                    cfg
);

  logic       wr;
  logic [2:0] index;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign index  = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_id   <= 8'd0;
      cfg.first_msg  <= 8'd0;
      cfg.second_id  <= 8'd1;
      cfg.known_mask <= '0;
    end else if (wr) begin
      unique case (index)
        fpcd_pkg::REG_FIRST_ID:  cfg.first_id      <= pwdata[7:0];
        fpcd_pkg::REG_FIRST_MSG: cfg.first_msg     <= pwdata[7:0];
        fpcd_pkg::REG_SECOND_ID: cfg.second_id     <= pwdata[7:0];
        fpcd_pkg::REG_MASK_0:    cfg.known_mask[0] <= pwdata;
        fpcd_pkg::REG_MASK_1:    cfg.known_mask[1] <= pwdata;
        fpcd_pkg::REG_MASK_2:    cfg.known_mask[2] <= pwdata;
        fpcd_pkg::REG_MASK_3:    cfg.known_mask[3] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      fpcd_pkg::REG_FIRST_ID:  prdata = {56'd0, cfg.first_id};
      fpcd_pkg::REG_FIRST_MSG: prdata = {56'd0, cfg.first_msg};
      fpcd_pkg::REG_SECOND_ID: prdata = {56'd0, cfg.second_id};
      fpcd_pkg::REG_MASK_0:    prdata = cfg.known_mask[0];
      fpcd_pkg::REG_MASK_1:    prdata = cfg.known_mask[1];
      fpcd_pkg::REG_MASK_2:    prdata = cfg.known_mask[2];
      fpcd_pkg::REG_MASK_3:    prdata = cfg.known_mask[3];
      default:                 prdata = '0;
    endcase
  end

endmodule

// File: src/fpcd_front.sv
// frame parser: tracks position and running sums, classifies each byte
// depends on fpcd_pkg; feeds fpcd_queue
`timescale 1ns / 1ps

module fpcd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            q_full,
  output logic            push,
  output fpcd_pkg::rec_t  push_rec
);

  logic [7:0] position, position_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] sender_held, sender_held_next;
  logic [7:0] message_held, message_held_next;
  logic [7:0] sum_a, sum_a_next;
  logic [7:0] sum_b, sum_b_next;
  logic [7:0] check_a, check_a_next;
  logic       accept;
  logic       emit;
  logic [8:0] pos_plus2;
  logic [7:0] acc_a;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign push      = accept && emit;
  assign pos_plus2 = {1'b0, position} + 9'd2;
  assign acc_a     = sum_a + in_byte;

  always_comb begin
    position_next     = position;
    frame_length_next = frame_length;
    sender_held_next  = sender_held;
    message_held_next = message_held;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    check_a_next      = check_a;
    emit              = 1'b0;
    push_rec.op       = fpcd_pkg::OP_HUNT;
    push_rec.data     = in_byte;
    push_rec.index    = position - 8'd4;
    push_rec.src      = sender_held;
    push_rec.msg      = message_held;
    push_rec.sum_ok   = (sum_a == check_a) && (sum_b == in_byte);
    priority if (position == 8'd0) begin
      if (in_byte == fpcd_pkg::START_MARK) begin
        position_next = 8'd1;
      end else begin
        emit        = 1'b1;
        push_rec.op = fpcd_pkg::OP_HUNT;
      end
    end else if (position == 8'd1) begin
      frame_length_next = in_byte;
      if (in_byte < fpcd_pkg::MIN_LENGTH) begin
        sum_a_next    = 8'd0;
        sum_b_next    = 8'd0;
        position_next = 8'd0;
        emit          = 1'b1;
        push_rec.op   = fpcd_pkg::OP_LENGTH;
      end else begin
        // sums restart at zero, so both take the length byte
        sum_a_next    = in_byte;
        sum_b_next    = in_byte;
        position_next = 8'd2;
      end
    end else if (position == 8'd2 || position == 8'd3) begin
      if (position == 8'd2) sender_held_next = in_byte;
      else message_held_next = in_byte;
      sum_a_next    = acc_a;
      sum_b_next    = sum_b + acc_a;
      position_next = position + 8'd1;
    end else if (pos_plus2 < {1'b0, frame_length}) begin
      sum_a_next    = acc_a;
      sum_b_next    = sum_b + acc_a;
      position_next = position + 8'd1;
      emit          = 1'b1;
      push_rec.op   = fpcd_pkg::OP_PAYLOAD;
    end else if (pos_plus2 == {1'b0, frame_length}) begin
      check_a_next  = in_byte;
      position_next = position + 8'd1;
    end else begin
      position_next = 8'd0;
      emit          = 1'b1;
      push_rec.op   = fpcd_pkg::OP_FRAME_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= 8'd0;
      frame_length <= 8'd0;
      sender_held  <= 8'd0;
      message_held <= 8'd0;
      sum_a        <= 8'd0;
      sum_b        <= 8'd0;
      check_a      <= 8'd0;
    end else if (accept) begin
      position     <= position_next;
      frame_length <= frame_length_next;
      sender_held  <= sender_held_next;
      message_held <= message_held_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      check_a      <= check_a_next;
    end
  end

endmodule

// File: src/fpcd_queue.sv
// short fifo of classified items between front and back
// depends on fpcd_pkg
`timescale 1ns / 1ps

module fpcd_queue #(
  parameter int unsigned DEPTH = fpcd_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpcd_pkg::rec_t  push_rec,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output fpcd_pkg::rec_t  head_rec
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fpcd_pkg::rec_t entries [DEPTH];
  logic [PTR_W-1:0] head, tail;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign q_valid  = (count != '0);
  assign head_rec = entries[head];

  always_ff @(posedge clk) begin
    if (push) entries[tail] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) tail <= (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;
      if (pop) head <= (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// File: src/fpcd_back.sv
// result stage: resolves frame status against the known ids and holds the output item
// depends on fpcd_pkg; fed by fpcd_queue and fpcd_cfg
`timescale 1ns / 1ps

module fpcd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  fpcd_pkg::rec_t  head_rec,
  output logic            pop,
  input  fpcd_pkg::cfg_t  cfg,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            kind,
  output logic [7:0]      data_byte,
  output logic [7:0]      byte_index,
  output logic [7:0]      source_id,
  output logic [7:0]      message_kind,
  output logic [2:0]      status
);

  fpcd_pkg::status_t end_status, status_next;
  logic              kind_next;
  logic [7:0]        data_next, index_next, src_next, msg_next;
  logic [63:0]       mask_word;
  logic              mask_bit;

  assign pop       = q_valid && (!out_valid || out_ready);
  assign mask_word = cfg.known_mask[head_rec.msg[7:6]];
  assign mask_bit  = mask_word[head_rec.msg[5:0]];

  always_comb begin
    priority if (!head_rec.sum_ok) begin
      end_status = fpcd_pkg::ST_CHECKSUM;
    end else if (head_rec.src == cfg.first_id) begin
      // first source wins when both ids match
      end_status = (head_rec.msg == cfg.first_msg) ? fpcd_pkg::ST_OK
                                                   : fpcd_pkg::ST_FIRST_MSG;
    end else if (head_rec.src == cfg.second_id) begin
      end_status = mask_bit ? fpcd_pkg::ST_OK : fpcd_pkg::ST_SECOND_MSG;
    end else begin
      end_status = fpcd_pkg::ST_SENDER;
    end
  end

  always_comb begin
    kind_next   = 1'b1;
    data_next   = 8'd0;
    index_next  = 8'd0;
    src_next    = 8'd0;
    msg_next    = 8'd0;
    status_next = fpcd_pkg::ST_OK;
    unique case (head_rec.op)
      fpcd_pkg::OP_PAYLOAD: begin
        kind_next  = 1'b0;
        data_next  = head_rec.data;
        index_next = head_rec.index;
        src_next   = head_rec.src;
        msg_next   = head_rec.msg;
      end
      fpcd_pkg::OP_HUNT:   status_next = fpcd_pkg::ST_START;
      fpcd_pkg::OP_LENGTH: status_next = fpcd_pkg::ST_LENGTH;
      fpcd_pkg::OP_FRAME_END: begin
        src_next    = head_rec.src;
        msg_next    = head_rec.msg;
        status_next = end_status;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind         <= kind_next;
      data_byte    <= data_next;
      byte_index   <= index_next;
      source_id    <= src_next;
      message_kind <= msg_next;
      status       <= status_next;
    end
  end

endmodule

// File: src/framed_packet_checksum_decoder_unit.sv
// Frame decoder for a start-marked byte stream with two 8-bit running checksums.
// One byte is taken per clock whenever the internal queue has room. A result
// (payload byte or frame status) is written to the item queue at the edge that
// takes its byte and is loaded into the output register once that register is
// empty or its item is being taken. Results are held in the output register
// until taken, and the queue lets the parser keep accepting bytes meanwhile until
// its entries fill. Payload bytes are delivered as they arrive: drop them if the
// frame's closing status is not ok. Registers sit at byte address 8*index on a
// 64-bit apb-style port and should be written only while no frame is in flight.
// depends on fpcd_pkg, fpcd_cfg, fpcd_front, fpcd_queue, fpcd_back
`timescale 1ns / 1ps

module framed_packet_checksum_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = fpcd_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fpcd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fpcd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fpcd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              kind,
  output logic [7:0]                        data_byte,
  output logic [7:0]                        byte_index,
  output logic [7:0]                        source_id,
  output logic [7:0]                        message_kind,
  output logic [2:0]                        status
);

  fpcd_pkg::cfg_t cfg;
  fpcd_pkg::rec_t push_rec, head_rec;
  logic           push, pop, q_full, q_valid;

  fpcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpcd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  fpcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head_rec (head_rec)
  );

  fpcd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .head_rec     (head_rec),
    .pop          (pop),
    .cfg          (cfg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .source_id    (source_id),
    .message_kind (message_kind),
    .status       (status)
  );

endmodule

// File: dv/framed_packet_checksum_decoder_unit_tb.sv
// testbench for framed_packet_checksum_decoder_unit: directed and random frame streams,
// a byte-level predictor of the decoder, and apb register writes with readback
// depends on fpcd_pkg and framed_packet_checksum_decoder_unit
`timescale 1ns / 1ps

module framed_packet_checksum_decoder_unit_tb;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_BYTES = 40;
  localparam int NUM_PHASES = 8;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic              kind;
    logic [7:0]        data;
    logic [7:0]        idx;
    logic [7:0]        src;
    logic [7:0]        msg;
    fpcd_pkg::status_t st;
  } decoded_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fpcd_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [fpcd_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [fpcd_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic kind;
  logic [7:0] data_byte;
  logic [7:0] byte_index;
  logic [7:0] source_id;
  logic [7:0] message_kind;
  logic [2:0] status;

  framed_packet_checksum_decoder_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .data_byte(data_byte), .byte_index(byte_index),
    .source_id(source_id), .message_kind(message_kind), .status(status)
  );

  always #2 clk = ~clk;

  // stream to send and decoded items still owed by the block
  logic [7:0] pending_bytes[$];
  decoded_item_t expected_items[$];
  int n_pushed = 0;
  int n_accepted = 0;
  bit in_taken = 1'b0;
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // register copy
  logic [7:0]  cfg_first_id = 8'd0;
  logic [7:0]  cfg_first_msg = 8'd0;
  logic [7:0]  cfg_second_id = 8'd1;
  logic [63:0] cfg_mask[4] = '{64'd0, 64'd0, 64'd0, 64'd0};

  // decoder state copy
  int          dec_pos = 0;
  int          dec_len = 0;
  logic [7:0]  held_src = 8'd0;
  logic [7:0]  held_msg = 8'd0;
  logic [7:0]  sum_lo = 8'd0;
  logic [7:0]  sum_hi = 8'd0;
  logic [7:0]  held_check_a = 8'd0;

  task automatic report_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic run_sums(input logic [7:0] b);
    sum_lo = sum_lo + b;
    sum_hi = sum_hi + sum_lo;
  endtask

  function automatic fpcd_pkg::status_t closing_status(input logic [7:0] check_b);
    if (sum_lo != held_check_a || sum_hi != check_b) return fpcd_pkg::ST_CHECKSUM;
    if (held_src == cfg_first_id)
      return (held_msg == cfg_first_msg) ? fpcd_pkg::ST_OK : fpcd_pkg::ST_FIRST_MSG;
    if (held_src == cfg_second_id)
      return cfg_mask[held_msg[7:6]][held_msg[5:0]] ? fpcd_pkg::ST_OK
                                                    : fpcd_pkg::ST_SECOND_MSG;
    return fpcd_pkg::ST_SENDER;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    decoded_item_t r;
    r = '0;
    r.kind = 1'b1;
    if (dec_pos == 0) begin
      if (b == fpcd_pkg::START_MARK) begin
        dec_pos = 1;
      end else begin
        r.st = fpcd_pkg::ST_START;
        expected_items.push_back(r);
      end
    end else if (dec_pos == 1) begin
      dec_len = b;
      sum_lo = 8'd0;
      sum_hi = 8'd0;
      if (b < fpcd_pkg::MIN_LENGTH) begin
        dec_pos = 0;
        r.st = fpcd_pkg::ST_LENGTH;
        expected_items.push_back(r);
      end else begin
        run_sums(b);
        dec_pos = 2;
      end
    end else if (dec_pos == 2) begin
      held_src = b;
      run_sums(b);
      dec_pos = 3;
    end else if (dec_pos == 3) begin
      held_msg = b;
      run_sums(b);
      dec_pos = 4;
    end else if (dec_pos + 2 < dec_len) begin
      run_sums(b);
      r.kind = 1'b0;
      r.data = b;
      r.idx = 8'(dec_pos - 4);
      r.src = held_src;
      r.msg = held_msg;
      r.st = fpcd_pkg::ST_OK;
      expected_items.push_back(r);
      dec_pos++;
    end else if (dec_pos + 2 == dec_len) begin
      held_check_a = b;
      dec_pos++;
    end else begin
      dec_pos = 0;
      r.src = held_src;
      r.msg = held_msg;
      r.st = closing_status(b);
      expected_items.push_back(r);
    end
  endtask

  // driver: one item presented at a time, held until taken
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 1'b0;
      if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_byte <= pending_bytes.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // monitor: predict on accepted input, check on accepted output
  always @(posedge clk) begin
    decoded_item_t want;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        n_accepted++;
        decode_byte(in_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_items.size() == 0) begin
          report_error($sformatf(
            "unexpected item kind=%0d data=%0h idx=%0d src=%0h msg=%0h st=%0d",
            kind, data_byte, byte_index, source_id, message_kind, status));
        end else begin
          want = expected_items.pop_front();
          if (kind !== want.kind || data_byte !== want.data || byte_index !== want.idx ||
              source_id !== want.src || message_kind !== want.msg || status !== want.st)
            report_error($sformatf({
              "mismatch exp kind=%0d data=%0h idx=%0d src=%0h msg=%0h st=%0d, ",
              "got %0d %0h %0d %0h %0h %0d"},
              want.kind, want.data, want.idx, want.src, want.msg, want.st,
              kind, data_byte, byte_index, source_id, message_kind, status));
        end
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes.push_back(b);
    n_pushed++;
  endtask

  // corrupt: 0 none, 1 first check byte, 2 second check byte
  task automatic queue_frame(input logic [7:0] src, input logic [7:0] msg, input int plen,
                             input int corrupt);
    logic [7:0] body[$];
    logic [7:0] a;
    logic [7:0] c;
    a = 8'd0;
    c = 8'd0;
    body.push_back(8'(plen + 6));
    body.push_back(src);
    body.push_back(msg);
    for (int i = 0; i < plen; i++) body.push_back(8'($urandom));
    push_byte(fpcd_pkg::START_MARK);
    foreach (body[i]) begin
      a = a + body[i];
      c = c + a;
      push_byte(body[i]);
    end
    if (corrupt == 1) a = a ^ (8'd1 << $urandom_range(0, 7));
    if (corrupt == 2) c = c ^ (8'd1 << $urandom_range(0, 7));
    push_byte(a);
    push_byte(c);
  endtask

  task automatic wait_idle();
    while (n_accepted != n_pushed || expected_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [2:0] idx, input logic [63:0] wdata,
                          output logic [63:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 3'b000};
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_config(input logic [63:0] fid, input logic [63:0] fmsg,
                              input logic [63:0] sid, input logic [63:0] m0,
                              input logic [63:0] m1, input logic [63:0] m2,
                              input logic [63:0] m3);
    logic [63:0] vals[7];
    logic [2:0]  regs[7];
    logic [63:0] keep;
    logic [63:0] rd;
    vals = '{fid, fmsg, sid, m0, m1, m2, m3};
    regs = '{fpcd_pkg::REG_FIRST_ID, fpcd_pkg::REG_FIRST_MSG, fpcd_pkg::REG_SECOND_ID,
             fpcd_pkg::REG_MASK_0, fpcd_pkg::REG_MASK_1, fpcd_pkg::REG_MASK_2,
             fpcd_pkg::REG_MASK_3};
    for (int i = 0; i < 7; i++) begin
      apb_xfer(1'b1, regs[i], vals[i], rd);
      apb_xfer(1'b0, regs[i], 64'd0, rd);
      keep = (i < 3) ? 64'hFF : '1;
      if ((rd & keep) !== (vals[i] & keep))
        report_error($sformatf("register %0d read %0h, wrote %0h", regs[i], rd, vals[i]));
    end
    cfg_first_id = fid[7:0];
    cfg_first_msg = fmsg[7:0];
    cfg_second_id = sid[7:0];
    cfg_mask = '{m0, m1, m2, m3};
  endtask

  // mostly well-formed frames with random content, some noise and broken frames
  task automatic random_traffic(input int target);
    int start;
    int r;
    int n;
    logic [7:0] src;
    logic [7:0] msg;
    start = n_pushed;
    while (n_pushed - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(0, 99);
        src = (n < 40) ? cfg_first_id : (n < 80) ? cfg_second_id : 8'($urandom);
        msg = 8'($urandom);
        if (src == cfg_first_id && $urandom_range(0, 99) < 70) begin
          msg = cfg_first_msg;
        end else if (src == cfg_second_id && $urandom_range(0, 99) < 60) begin
          for (int k = 0; k < 8 && !cfg_mask[msg[7:6]][msg[5:0]]; k++) msg = 8'($urandom);
        end
        n = $urandom_range(0, 99);
        queue_frame(src, msg, $urandom_range(0, 12), (n < 10) ? 1 : (n < 20) ? 2 : 0);
      end else if (r < 80) begin
        push_byte(fpcd_pkg::START_MARK);
        push_byte(8'($urandom_range(0, fpcd_pkg::MIN_LENGTH - 1)));
      end else if (r < 90) begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) push_byte(8'($urandom));
      end else begin
        // truncated frame, later bytes fall into it
        push_byte(fpcd_pkg::START_MARK);
        push_byte(8'($urandom_range(fpcd_pkg::MIN_LENGTH, 24)));
        n = $urandom_range(0, 5);
        for (int k = 0; k < n; k++) push_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0]  same_id;
    logic [63:0] rd;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: stray bytes, short lengths, statuses under reset registers
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h98);
    push_byte(fpcd_pkg::START_MARK);
    push_byte(8'h00);
    push_byte(fpcd_pkg::START_MARK);
    push_byte(fpcd_pkg::MIN_LENGTH - 8'd1);
    queue_frame(8'h00, 8'h00, 0, 0);
    queue_frame(8'h01, 8'h80, 2, 0);
    queue_frame(8'h00, 8'h00, 1, 2);
    queue_frame(8'h7E, 8'h00, 0, 0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        case (p)
          1: apply_config(64'hFF, 64'hFF, 64'h00, '1, '1, '1, '1);
          2: apply_config(64'h00, 64'h00, 64'hFF, 64'd0, 64'd0, 64'd0, 64'd0);
          4: begin
            same_id = 8'($urandom);
            apply_config({$urandom, $urandom}, {$urandom, $urandom}, {56'd0, same_id},
                         {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom});
            // both sender registers equal: first source wins
            cfg_first_id = same_id;
            apply_config({56'd0, same_id}, {56'd0, cfg_first_msg}, {56'd0, same_id},
                         cfg_mask[0], cfg_mask[1], cfg_mask[2], cfg_mask[3]);
          end
          5: apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          {32{2'b01}}, {32{2'b10}}, {32{2'b01}}, {32{2'b10}});
          default: apply_config({$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom});
        endcase
        // a write to an address with no register must change nothing
        if (p == 7) apb_xfer(1'b1, REG_UNUSED, {$urandom, $urandom}, rd);
      end
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 55; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 55; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      if (p == 3) queue_frame(cfg_second_id, 8'($urandom), 249, 0);
      random_traffic(PHASE_BYTES);
    end

    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/fpcd_pkg.sv
src/fpcd_cfg.sv
src/fpcd_front.sv
src/fpcd_queue.sv
src/fpcd_back.sv
src/framed_packet_checksum_decoder_unit.sv
dv/framed_packet_checksum_decoder_unit_tb.sv
